>>> rtl/core/assert_macros.svh
// assertion macros used by the top level of the decimal integer parser
// no dependencies; define ASSERT_OFF to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

>>> rtl/core/dip_pkg.sv
// types and constants of the decimal integer parser
// no dependencies; used by the scanner, the result stage and the top level
`timescale 1ns / 1ps

package dip_pkg;

  typedef enum logic [1:0] {
    MODE_S64 = 2'd0,
    MODE_S32 = 2'd1,
    MODE_U64 = 2'd2,
    MODE_RSV = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    PH_START  = 4'b0001,
    PH_LEAD   = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_TRAIL  = 4'b1000
  } phase_t;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned HALF_W  = 32;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       byte_present;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [VALUE_W-1:0] parsed_value;
    logic               parse_ok;
    logic               overflow_flag;
  } out_t;

  // end-of-string summary handed from the scanner to the result stage
  typedef struct packed {
    logic [VALUE_W-1:0] mag;
    logic               neg;
    logic               ok;
    logic               wrap;
  } raw_t;

  typedef struct packed {
    logic in_string;
  } status_t;

endpackage

>>> rtl/core/dip_step.sv
// per-byte scanner: phase, accumulator and flags, plus end-of-string register
// depends on dip_pkg
`timescale 1ns / 1ps

module dip_step (
  input  logic            clk,
  input  logic            rst,
  input  dip_pkg::mode_t  mode,
  input  logic            item_valid,
  input  dip_pkg::in_t    item,
  output logic            item_ready,
  output logic            raw_valid,
  output dip_pkg::raw_t   raw,
  input  logic            raw_ready,
  output dip_pkg::status_t status
);
  import dip_pkg::*;

  localparam int unsigned SUM_W = VALUE_W + 4;

  phase_t             phase, phase_next;
  logic [VALUE_W-1:0] acc, acc_next;
  logic               neg, neg_next;
  logic               err, err_next;
  logic               wrap, wrap_next;

  logic               is_digit, is_plus, is_minus, is_space, add_en;
  logic               mode32;
  logic [VALUE_W-1:0] acc_src;
  logic [SUM_W-1:0]   acc_wide, sum;
  logic [VALUE_W-1:0] acc_sum;
  logic               wrap_add;
  logic               take;
  raw_t               raw_next;

  assign mode32   = (mode == MODE_S32);
  assign is_digit = (item.char_byte >= CHAR_ZERO) && (item.char_byte <= CHAR_NINE);
  assign is_plus  = (item.char_byte == CHAR_PLUS);
  assign is_minus = (item.char_byte == CHAR_MINUS) && (mode != MODE_U64);
  assign is_space = (item.char_byte == CHAR_SPACE) || (item.char_byte == CHAR_TAB) ||
                    (item.char_byte == CHAR_CR);

  // times ten as shift-add; 4 guard bits catch the wrap
  assign acc_src  = mode32 ? {{(VALUE_W-HALF_W){1'b0}}, acc[HALF_W-1:0]} : acc;
  assign acc_wide = {4'b0000, acc_src};
  assign sum      = (acc_wide << 3) + (acc_wide << 1) +
                    {{(SUM_W-4){1'b0}}, item.char_byte[3:0]};
  assign wrap_add = mode32 ? (sum[SUM_W-1:HALF_W] != '0) : (sum[SUM_W-1:VALUE_W] != '0);
  assign acc_sum  = mode32 ? {{(VALUE_W-HALF_W){1'b0}}, sum[HALF_W-1:0]} : sum[VALUE_W-1:0];

  always_comb begin
    phase_next = phase;
    neg_next   = neg;
    err_next   = err;
    add_en     = 1'b0;
    if (item.byte_present && !err) begin
      unique case (phase)
        PH_START: begin
          if (is_plus || is_minus) begin
            neg_next   = is_minus;
            phase_next = PH_LEAD;
          end else if (is_space) begin
            phase_next = PH_LEAD;
          end else if (is_digit) begin
            add_en     = 1'b1;
            phase_next = PH_DIGITS;
          end else begin
            err_next   = 1'b1;
            phase_next = PH_TRAIL;
          end
        end
        PH_LEAD: begin
          if (is_digit) begin
            add_en     = 1'b1;
            phase_next = PH_DIGITS;
          end else if (!is_space) begin
            err_next = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            add_en = 1'b1;
          end else if (is_space) begin
            phase_next = PH_TRAIL;
          end else begin
            err_next = 1'b1;
          end
        end
        default: begin
          if (!is_space) begin
            err_next = 1'b1;
          end
        end
      endcase
    end
    acc_next  = add_en ? acc_sum : acc;
    wrap_next = wrap || (add_en && wrap_add);
  end

  always_comb begin
    raw_next.mag  = acc_next;
    raw_next.neg  = neg_next;
    raw_next.ok   = !err_next && (phase_next != PH_START);
    raw_next.wrap = wrap_next;
  end

  // a byte without a result never waits on the result stage
  assign item_ready = !item.last_byte || !raw_valid || raw_ready;
  assign take       = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      acc   <= '0;
      neg   <= 1'b0;
      err   <= 1'b0;
      wrap  <= 1'b0;
    end else if (take) begin
      if (item.last_byte) begin
        phase <= PH_START;
        acc   <= '0;
        neg   <= 1'b0;
        err   <= 1'b0;
        wrap  <= 1'b0;
      end else begin
        phase <= phase_next;
        acc   <= acc_next;
        neg   <= neg_next;
        err   <= err_next;
        wrap  <= wrap_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_valid <= 1'b0;
    end else if (take && item.last_byte) begin
      raw_valid <= 1'b1;
    end else if (raw_ready) begin
      raw_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && item.last_byte) begin
      raw <= raw_next;
    end
  end

  assign status.in_string = (phase != PH_START);

endmodule

>>> rtl/core/dip_final.sv
// result stage: sign, range check and output register
// depends on dip_pkg
`timescale 1ns / 1ps

module dip_final (
  input  logic           clk,
  input  logic           rst,
  input  dip_pkg::mode_t mode,
  input  logic           raw_valid,
  input  dip_pkg::raw_t  raw,
  output logic           raw_ready,
  output logic           result_valid,
  output dip_pkg::out_t  result_data,
  input  logic           result_ready
);
  import dip_pkg::*;

  logic [HALF_W-1:0]  mag32, val32;
  logic [VALUE_W-1:0] val64, value;
  logic               ovf;
  out_t               result_next;

  assign mag32 = raw.mag[HALF_W-1:0];
  assign val32 = raw.neg ? (~mag32 + 1'b1) : mag32;
  assign val64 = raw.neg ? (~raw.mag + 1'b1) : raw.mag;

  always_comb begin
    unique case (mode)
      MODE_S32: begin
        value = {{(VALUE_W-HALF_W){val32[HALF_W-1]}}, val32};
        ovf   = raw.wrap || (raw.neg ? (mag32[HALF_W-1] && (mag32[HALF_W-2:0] != '0))
                                     : mag32[HALF_W-1]);
      end
      MODE_U64: begin
        value = val64;
        ovf   = raw.wrap || (raw.neg && (raw.mag != '0));
      end
      default: begin
        value = val64;
        ovf   = raw.wrap || (raw.neg ? (raw.mag[VALUE_W-1] && (raw.mag[VALUE_W-2:0] != '0))
                                     : raw.mag[VALUE_W-1]);
      end
    endcase
    result_next.parsed_value  = raw.ok ? value : '0;
    result_next.parse_ok      = raw.ok;
    result_next.overflow_flag = raw.ok && ovf;
  end

  assign raw_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (raw_ready) begin
      result_valid <= raw_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (raw_valid && raw_ready) begin
      result_data <= result_next;
    end
  end

endmodule

>>> rtl/core/decimal_integer_parser.sv
// top level of the decimal integer parser: input register, scanner, result stage
// depends on dip_pkg, dip_step, dip_final and assert_macros.svh
`timescale 1ns / 1ps

//  channel   signals                              transaction
//  byte      byte_valid byte_ready byte_data      one string byte, presence and end mark
//  result    result_valid result_ready result_data value, ok and overflow per string
//  config    cfg_we cfg_wdata                     parse mode, written without wait
//
// one byte per cycle sustained while no last byte waits; the limit is the times-ten add in the scanner
// after its last byte is accepted into the input register, a result moves to the end-of-string
// register and then to the output register, where it becomes valid
// synchronous reset clears the valid bits, the scan state and the mode (signed 64)
// bytes that do not end a string keep flowing while a result waits to be taken;
// a last byte waits only if both the end-of-string and output registers are full

`include "assert_macros.svh"

module decimal_integer_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          byte_valid,
  output logic          byte_ready,
  input  dip_pkg::in_t  byte_data,
  output logic          result_valid,
  input  logic          result_ready,
  output dip_pkg::out_t result_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_wdata
);
  import dip_pkg::*;

  // mode register; the user must write it only while the block is idle, the block does not enforce it
  mode_t   parse_mode;

  // input register
  logic    s1_valid;
  in_t     s1_data;
  logic    s1_ready;

  // scanner to result stage
  logic    raw_valid;
  raw_t    raw;
  logic    raw_ready;
  status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode <= MODE_S64;
    end else if (cfg_we) begin
      parse_mode <= mode_t'(cfg_wdata);
    end
  end

  // input register refills in the cycle it empties
  assign byte_ready = !s1_valid || s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_ready) begin
      s1_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      s1_data <= byte_data;
    end
  end

  // per-byte scan; state clears after the last byte
  dip_step u_step (
    .clk        (clk),
    .rst        (rst),
    .mode       (parse_mode),
    .item_valid (s1_valid),
    .item       (s1_data),
    .item_ready (s1_ready),
    .raw_valid  (raw_valid),
    .raw        (raw),
    .raw_ready  (raw_ready),
    .status     (status)
  );

  // negation, range check and the output register
  dip_final u_final (
    .clk          (clk),
    .rst          (rst),
    .mode         (parse_mode),
    .raw_valid    (raw_valid),
    .raw          (raw),
    .raw_ready    (raw_ready),
    .result_valid (result_valid),
    .result_data  (result_data),
    .result_ready (result_ready)
  );

  // a string end always leaves the scanner back at the start of a string
  `ASSERT_NEXT(a_clear_after_last, clk, rst, s1_valid && s1_ready && s1_data.last_byte, !status.in_string, "scan state not cleared after last byte")

  // a pending end-of-string summary is never dropped while the output stalls
  `ASSERT_NEXT(a_raw_held, clk, rst, raw_valid && !raw_ready, raw_valid && $stable(raw), "end-of-string summary lost during stall")

  // malformed strings report zero and no overflow
  `ASSERT_IMPLIES(a_error_zero, clk, rst, result_valid && !result_data.parse_ok, (result_data.parsed_value == '0) && !result_data.overflow_flag, "error result carries data")

  // in the 32-bit mode the upper word is the sign extension of bit 31
  `ASSERT_IMPLIES(a_s32_extend, clk, rst, result_valid && (parse_mode == MODE_S32), result_data.parsed_value[VALUE_W-1:HALF_W] == {(VALUE_W-HALF_W){result_data.parsed_value[HALF_W-1]}}, "32-bit result not sign extended")

endmodule

>>> sim/decimal_integer_parser_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the decimal integer parser: directed strings, then random ones
// depends on dip_pkg and the rtl top decimal_integer_parser; reads no files

module decimal_integer_parser_tb;
  import dip_pkg::*;

  typedef logic [7:0] text_t[$];

  // largest magnitude that can still take one more digit without wrapping 64 bits
  localparam logic [63:0] SCALE_LIMIT = 64'h1999_9999_9999_9999;
  // cycles to let bytes that give no result clear the three-stage pipe
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 400;
  localparam int PHASE_BYTES  = 200;

  // magnitudes around the signed, unsigned and times-ten limits of both widths
  localparam logic [63:0] BOUNDARY_VALUES [9] = '{
    64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
    64'h1999_9999_9999_9999, 64'h0000_0000_7FFF_FFFF, 64'h0000_0000_8000_0000,
    64'h0000_0000_FFFF_FFFF, 64'h0000_0000_1999_9999, 64'h0000_0001_0000_0000
  };

  // mode of each random phase; both ends of the range and the reserved code appear
  localparam mode_t PHASE_MODES [8] = '{
    MODE_U64, MODE_S32, MODE_S64, MODE_RSV, MODE_S32, MODE_U64, MODE_S64, MODE_S32
  };

  // scan state mirror plus the queue of results still owed by the block
  class parse_scoreboard;
    mode_t       mode;
    phase_t      phase;
    logic [63:0] magnitude;
    bit          minus_sign;
    bit          malformed;
    bit          wrapped;
    out_t        expected_q[$];
    int          errors;

    function new();
      mode   = MODE_S64;
      errors = 0;
      clear_string();
    endfunction

    function void set_mode(mode_t m);
      mode = m;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void clear_string();
      phase      = PH_START;
      magnitude  = '0;
      minus_sign = 1'b0;
      malformed  = 1'b0;
      wrapped    = 1'b0;
    endfunction

    // times ten plus digit; the 32-bit mode works on the low word only
    function void add_digit(logic [3:0] d);
      logic [63:0] widened;
      if (mode == MODE_S32) begin
        widened = {32'd0, magnitude[31:0]} * 64'd10 + {60'd0, d};
        if (widened[63:32] != 32'd0) wrapped = 1'b1;
        magnitude = {32'd0, widened[31:0]};
      end else begin
        if (magnitude > SCALE_LIMIT || (magnitude == SCALE_LIMIT && d > 4'd5))
          wrapped = 1'b1;
        magnitude = magnitude * 64'd10 + {60'd0, d};
      end
    endfunction

    function void take_byte(logic [7:0] c);
      bit is_digit;
      bit is_sign;
      bit is_blank;
      is_digit = c >= CHAR_ZERO && c <= CHAR_NINE;
      is_sign  = c == CHAR_PLUS || (c == CHAR_MINUS && mode != MODE_U64);
      is_blank = c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR;
      if (malformed) return;
      case (phase)
        PH_START: begin
          if (is_sign) begin
            minus_sign = c == CHAR_MINUS;
            phase = PH_LEAD;
          end else if (is_blank) begin
            phase = PH_LEAD;
          end else if (is_digit) begin
            add_digit(c[3:0]);
            phase = PH_DIGITS;
          end else begin
            malformed = 1'b1;
            phase = PH_TRAIL;
          end
        end
        PH_LEAD: begin
          if (is_digit) begin
            add_digit(c[3:0]);
            phase = PH_DIGITS;
          end else if (!is_blank) begin
            malformed = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (is_digit) add_digit(c[3:0]);
          else if (is_blank) phase = PH_TRAIL;
          else malformed = 1'b1;
        end
        default: begin
          if (!is_blank) malformed = 1'b1;
        end
      endcase
    endfunction

    // called for every accepted input transaction
    function void note_input(in_t item);
      logic [63:0] mag;
      out_t        want;
      if (item.byte_present) take_byte(item.char_byte);
      if (!item.last_byte) return;
      want = '0;
      want.parse_ok = !malformed && phase != PH_START;
      if (want.parse_ok) begin
        want.overflow_flag = wrapped;
        if (mode == MODE_S32) begin
          mag = {32'd0, magnitude[31:0]};
          if (minus_sign ? mag > 64'h8000_0000 : mag > 64'h7FFF_FFFF)
            want.overflow_flag = 1'b1;
          mag = minus_sign ? -mag : mag;
          want.parsed_value = {{32{mag[31]}}, mag[31:0]};
        end else begin
          mag = magnitude;
          if (mode == MODE_U64) begin
            if (minus_sign && mag != 64'd0) want.overflow_flag = 1'b1;
          end else if (minus_sign ? mag > 64'h8000_0000_0000_0000
                                  : mag > 64'h7FFF_FFFF_FFFF_FFFF) begin
            want.overflow_flag = 1'b1;
          end
          want.parsed_value = minus_sign ? -mag : mag;
        end
      end
      expected_q.push_back(want);
      clear_string();
    endfunction

    // called for every accepted result transaction
    function void check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: value %h ok %b overflow %b", $time,
                 got.parsed_value, got.parse_ok, got.overflow_flag);
        return;
      end
      want = expected_q.pop_front();
      if (got.parsed_value !== want.parsed_value) begin
        errors++;
        $display("%0t parsed_value: expected %h actual %h", $time,
                 want.parsed_value, got.parsed_value);
      end
      if (got.parse_ok !== want.parse_ok) begin
        errors++;
        $display("%0t parse_ok: expected %b actual %b", $time, want.parse_ok, got.parse_ok);
      end
      if (got.overflow_flag !== want.overflow_flag) begin
        errors++;
        $display("%0t overflow_flag: expected %b actual %b", $time,
                 want.overflow_flag, got.overflow_flag);
      end
    endfunction
  endclass

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       byte_valid   = 1'b0;
  logic       byte_ready;
  in_t        byte_data    = '0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  out_t       result_data;
  logic       cfg_we       = 1'b0;
  logic [1:0] cfg_wdata    = 2'd0;

  parse_scoreboard board = new;

  // sender and receiver idle rates in percent, set per phase
  int gap_pct    = 0;
  int stall_pct  = 0;
  // raised by the stimulus, cleared by the receiver once its long hold is over
  bit hold_request = 1'b0;
  int bytes_sent   = 0;

  decimal_integer_parser u_top (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // both channels are sampled at the edge, before any nonblocking update lands
  always @(posedge clk) begin
    if (!rst) begin
      if (byte_valid && byte_ready) board.note_input(byte_data);
      if (result_valid && result_ready) board.check_result(result_data);
    end
  end

  // result side: mostly ready, random stall bursts, and one long hold on request
  initial begin
    @(posedge clk);
    forever begin
      if (hold_request) begin
        result_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        result_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic in_t make_item(logic [7:0] c, logic present, logic last);
    in_t item;
    item.char_byte    = c;
    item.byte_present = present;
    item.last_byte    = last;
    return item;
  endfunction

  function automatic logic [7:0] digit(int unsigned d);
    return 8'(CHAR_ZERO + d);
  endfunction

  function automatic logic [7:0] blank();
    case ($urandom_range(0, 2))
      0:       return CHAR_SPACE;
      1:       return CHAR_TAB;
      default: return CHAR_CR;
    endcase
  endfunction

  // digit run: random length, a value near a limit, or a short one
  function automatic text_t number_text();
    text_t       t;
    string       s;
    logic [63:0] v;
    case ($urandom_range(0, 3))
      0: begin
        repeat ($urandom_range(1, 22)) t.push_back(digit($urandom_range(0, 9)));
      end
      1, 2: begin
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) t.push_back(CHAR_ZERO);
        v = BOUNDARY_VALUES[$urandom_range(0, 8)] + 64'($urandom_range(0, 2)) - 64'd1;
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
        // one more digit can cross the times-ten limit
        if ($urandom_range(0, 2) == 0) t.push_back(digit($urandom_range(0, 9)));
      end
      default: begin
        repeat ($urandom_range(1, 3)) t.push_back(digit($urandom_range(0, 9)));
      end
    endcase
    return t;
  endfunction

  function automatic text_t well_formed_text();
    text_t t;
    text_t digits;
    case ($urandom_range(0, 3))
      0:       t.push_back(CHAR_PLUS);
      1:       t.push_back(CHAR_MINUS);
      default: ;
    endcase
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) t.push_back(blank());
    digits = number_text();
    foreach (digits[i]) t.push_back(digits[i]);
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) t.push_back(blank());
    return t;
  endfunction

  // good string with one flaw: stray byte, late sign, digit after trailing blank
  function automatic text_t broken_text();
    text_t t;
    t = well_formed_text();
    case ($urandom_range(0, 3))
      0: t[$urandom_range(0, t.size() - 1)] = 8'($urandom);
      1: t.insert($urandom_range(1, t.size()), $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
      2: begin
        t.push_back(blank());
        t.push_back(digit($urandom_range(0, 9)));
      end
      default: t.insert($urandom_range(0, t.size()), 8'($urandom_range(8'h21, 8'h7E)));
    endcase
    return t;
  endfunction

  function automatic text_t noise_text();
    text_t t;
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 3))
        0:       t.push_back(8'($urandom));
        1:       t.push_back(blank());
        2:       t.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
        default: t.push_back(digit($urandom_range(0, 9)));
      endcase
    end
    return t;
  endfunction

  // empty, sign only, blanks only, or sign and blanks
  function automatic text_t special_text();
    text_t t;
    case ($urandom_range(0, 3))
      0: ;
      1: t.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
      2: repeat ($urandom_range(1, 3)) t.push_back(blank());
      default: begin
        t.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
        repeat ($urandom_range(1, 2)) t.push_back(blank());
      end
    endcase
    return t;
  endfunction

  // one input transaction; valid stays up if the next call comes in the same step
  task automatic send_item(in_t item);
    logic [31:0] junk;
    byte_valid <= 1'b1;
    byte_data  <= item;
    do @(posedge clk); while (!byte_ready);
    if ($urandom_range(0, 99) < gap_pct) begin
      junk = $urandom;
      byte_valid <= 1'b0;
      byte_data  <= junk[$bits(in_t)-1:0];
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // a string, with stray byteless items; the end mark is on the last byte or
  // on a byteless item of its own; an open string gets no end mark at all
  task automatic send_text(text_t t, bit close);
    bit split_end;
    split_end = close && (t.size() == 0 || $urandom_range(0, 4) == 0);
    foreach (t[i]) begin
      if ($urandom_range(0, 19) == 0) send_item(make_item(8'($urandom), 1'b0, 1'b0));
      send_item(make_item(t[i], 1'b1, close && !split_end && i == t.size() - 1));
      bytes_sent++;
    end
    if (split_end) send_item(make_item(8'($urandom), 1'b0, 1'b1));
  endtask

  // stop sending, let every owed result arrive, then let the pipe empty
  task automatic settle();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(mode_t m);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_mode(m);
  endtask

  initial begin
    text_t t;
    int    pick;
    int    target;
    bit    paused;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    gap_pct   = 20;
    stall_pct = 20;

    // directed strings in the reset mode, signed 64
    send_item(make_item(8'h00, 1'b0, 1'b1));               // empty string
    send_item(make_item(CHAR_PLUS, 1'b1, 1'b1));           // sign only
    send_item(make_item(CHAR_SPACE, 1'b1, 1'b1));          // blank only
    send_item(make_item(CHAR_MINUS, 1'b1, 1'b0));          // minus, byteless filler, digit
    send_item(make_item(8'hA5, 1'b0, 1'b0));
    send_item(make_item(digit(7), 1'b1, 1'b1));
    send_item(make_item(CHAR_TAB, 1'b1, 1'b0));            // leading tab, trailing cr
    send_item(make_item(digit(5), 1'b1, 1'b0));
    send_item(make_item(CHAR_CR, 1'b1, 1'b1));
    send_item(make_item(digit(1), 1'b1, 1'b0));            // digit after trailing blank
    send_item(make_item(CHAR_SPACE, 1'b1, 1'b0));
    send_item(make_item(digit(2), 1'b1, 1'b1));
    send_item(make_item(digit(1), 1'b1, 1'b0));            // sign after the first byte
    send_item(make_item(CHAR_MINUS, 1'b1, 1'b1));
    send_item(make_item(8'hFF, 1'b1, 1'b1));               // byte outside the alphabet
    send_item(make_item(digit(9), 1'b1, 1'b0));            // end mark on a byteless item
    send_item(make_item(8'h5A, 1'b0, 1'b1));
    send_item(make_item(digit(0), 1'b1, 1'b1));

    // minus taken in signed mode, string finished in unsigned mode
    send_item(make_item(CHAR_MINUS, 1'b1, 1'b0));
    write_mode(MODE_U64);
    send_item(make_item(digit(3), 1'b1, 1'b1));

    // mode change from 32-bit to the reserved code within a string
    write_mode(MODE_S32);
    send_item(make_item(digit(8), 1'b1, 1'b0));
    write_mode(MODE_RSV);
    send_item(make_item(digit(9), 1'b1, 1'b1));
    send_item(make_item(CHAR_MINUS, 1'b1, 1'b0));          // reserved code still takes minus
    send_item(make_item(digit(1), 1'b1, 1'b1));

    // random phases, one mode each
    foreach (PHASE_MODES[p]) begin
      write_mode(PHASE_MODES[p]);
      if (p == $size(PHASE_MODES) - 1) begin
        // closing stretch runs without any idling
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(3, 30);
        stall_pct = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(3, 30);
      end
      target = bytes_sent + PHASE_BYTES;
      paused = 1'b0;

      if (p == 2) begin
        // receiver holds off while one-digit strings keep coming, so the
        // block fills up and pushes back on the byte channel
        hold_request = 1'b1;
        repeat (30) begin
          send_item(make_item(digit($urandom_range(0, 9)), 1'b1, 1'b1));
          bytes_sent++;
        end
      end

      while (bytes_sent < target) begin
        if (p == 5 && !paused && bytes_sent > target - PHASE_BYTES / 2) begin
          // sender waits until every owed result is back
          settle();
          paused = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 68) t = well_formed_text();
        else if (pick < 83) t = broken_text();
        else if (pick < 93) t = noise_text();
        else t = special_text();
        send_text(t, 1'b1);
      end

      // sometimes leave a string open across the next mode change
      if (p != $size(PHASE_MODES) - 1 && $urandom_range(0, 1) == 1) begin
        t = well_formed_text();
        send_text(t, 1'b0);
      end
    end

    settle();
    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
